FILE: hw/rtl/xyli_pkg.sv
//------------------------------------------------------------------------------
// xyli_pkg
// Shared types and constants of the line and arc interpolator.
//------------------------------------------------------------------------------
package xyli_pkg;

	localparam int COORD_BITS_DEF = 20;
	localparam int STEP_BITS      = 20;
	localparam logic [STEP_BITS-1:0] MAX_STEPS_RST = '1;

	localparam logic [1:0] CMD_LINE  = 2'd0;
	localparam logic [1:0] CMD_ARC   = 2'd1;
	localparam logic [1:0] CMD_QUICK = 2'd2;
	localparam logic [1:0] CMD_STEP  = 2'd3;

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_LINE    = 2'd1;
	localparam logic [1:0] MODE_ARC_CW  = 2'd2;
	localparam logic [1:0] MODE_ARC_CCW = 2'd3;

	localparam logic [2:0] ST_MOVING = 3'd0;
	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_ARCERR = 3'd2;
	localparam logic [2:0] ST_IDLE   = 3'd3;
	localparam logic [2:0] ST_LIMIT  = 3'd4;

	localparam logic [3:0] QM_ALL  = 4'hF;
	localparam logic [3:0] QM_NO0  = 4'hE;
	localparam logic [3:0] QM_NO1  = 4'hD;
	localparam logic [3:0] QM_NO2  = 4'hB;
	localparam logic [3:0] QM_NO3  = 4'h7;

	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_QUICK = 3'd2;
	localparam logic [2:0] OP_STEP  = 3'd3;
	localparam logic [2:0] OP_MUL   = 3'd4;
	localparam logic [2:0] OP_ITER  = 3'd5;
	localparam logic [2:0] OP_FIN   = 3'd6;

	typedef struct packed {
		logic [2:0] op;
	} xyli_cmd_t;

	typedef struct packed {
		logic finish;
		logic busy;
	} xyli_stat_t;

	function automatic logic quad_err(input logic [3:0] m);
		return m == QM_ALL || m == QM_NO0 || m == QM_NO1 || m == QM_NO2 || m == QM_NO3;
	endfunction

endpackage

FILE: hw/rtl/xy_line_arc_interpolator_top.sv
// Step requests: a line step runs a serial restoring divider (one quotient bit a cycle)
// and an arc step a serial square root (one root bit a cycle); a step request that ends
// at once raises m_tvalid without either.
// One item at a time; the next request is taken once the point has been accepted.
// Start and quick commands give no result.
// Reset (arst_n, asynchronous) clears position and move state and sets max_steps to all ones.
//------------------------------------------------------------------------------
// xy_line_arc_interpolator_top
// Two-axis line and arc setpoint generator with an APB register port.
//------------------------------------------------------------------------------
module xy_line_arc_interpolator_top import xyli_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// command[1:0], target_x, target_y, center_off_x, center_off_y, arc_ccw; zero pad
	input  logic [((4*COORD_BITS+3+7)/8)*8-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// point_x, point_y, status[2:0]; zero pad
	output logic [((2*COORD_BITS+3+7)/8)*8-1:0] m_tdata,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int CW = COORD_BITS;
	localparam int OW = ((2*CW+3+7)/8)*8;

	localparam logic [2:0] ADDR_MAX_STEPS = 3'd0;

	logic [STEP_BITS-1:0] max_steps_q;
	xyli_cmd_t  cmd;
	xyli_stat_t stat;
	logic [CW-1:0] px, py;
	logic [2:0]    pst;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MAX_STEPS) ? 32'(max_steps_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q <= MAX_STEPS_RST;
		end else if (psel && penable && pwrite && paddr == ADDR_MAX_STEPS) begin
			max_steps_q <= pwdata[STEP_BITS-1:0];
		end
	end

	xyli_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_cmd(s_tdata[1:0]), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cmd(cmd), .stat(stat)
	);

	xyli_dp #(.COORD_BITS(CW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_cmd(s_tdata[1:0]),
		.tgt_x(s_tdata[2 +: CW]), .tgt_y(s_tdata[2+CW +: CW]),
		.off_x(s_tdata[2+2*CW +: CW]), .off_y(s_tdata[2+3*CW +: CW]),
		.ccw_in(s_tdata[2+4*CW]),
		.max_steps(max_steps_q),
		.pt_x(px), .pt_y(py), .pt_status(pst)
	);

	assign m_tdata = OW'({pst, py, px});

endmodule

FILE: hw/rtl/xyli_ctrl.sv
//------------------------------------------------------------------------------
// xyli_ctrl
// Sequencer: accepts a request, starts the datapath, holds the result.
//------------------------------------------------------------------------------
module xyli_ctrl import xyli_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_cmd,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output xyli_cmd_t  cmd,
	input  xyli_stat_t stat
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic       acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc       = in_valid && in_ready;

	always_comb begin
		cmd.op = OP_NONE;
		if (acc) begin
			case (in_cmd)
				CMD_LINE, CMD_ARC: cmd.op = OP_START;
				CMD_QUICK:         cmd.op = OP_QUICK;
				default:           cmd.op = OP_STEP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc && in_cmd == CMD_STEP) state_q <= S_RUN;
				end
				S_RUN: begin
					if (stat.finish) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
	a_fin_run: assert property (@(posedge clk) disable iff (!arst_n)
		stat.finish |-> state_q == S_RUN) else $error("finish outside run");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif

endmodule

FILE: hw/rtl/xyli_dp.sv
//------------------------------------------------------------------------------
// xyli_dp
// Position state, serial divider, serial square root and step logic.
//------------------------------------------------------------------------------
module xyli_dp import xyli_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  xyli_cmd_t               cmd,
	output xyli_stat_t              stat,
	input  logic [1:0]              in_cmd,
	input  logic [COORD_BITS-1:0]   tgt_x,
	input  logic [COORD_BITS-1:0]   tgt_y,
	input  logic [COORD_BITS-1:0]   off_x,
	input  logic [COORD_BITS-1:0]   off_y,
	input  logic                    ccw_in,
	input  logic [STEP_BITS-1:0]    max_steps,
	output logic [COORD_BITS-1:0]   pt_x,
	output logic [COORD_BITS-1:0]   pt_y,
	output logic [2:0]              pt_status
);

	localparam int CW  = COORD_BITS;
	localparam int DW  = CW + 2;          // difference / centre offset width
	localparam int PW  = 2 * DW;          // products and squared radius
	localparam int RW  = PW / 2;          // root width
	localparam int VW  = PW + DW;         // shifted divisor width
	localparam int CNW = $clog2(PW + 1);

	logic signed [CW-1:0]  cur_x_q, cur_y_q, sx_q, sy_q, ex_q, ey_q;
	logic signed [CW:0]    cx_q, cy_q;
	logic        [PW-1:0]  r2_q;
	logic        [3:0]     qm_q;
	logic        [1:0]     mode_q;
	logic [STEP_BITS-1:0]  steps_q;

	// Iteration registers of the divider and the root; rem_q and acc_q are shared.
	logic        [PW-1:0]  rem_q, acc_q, bit_q;
	logic        [VW-1:0]  den_q;
	logic        [CNW-1:0] cnt_q;
	logic                  busy_q, neg_q, sqrt_q, side_q, fin_q;
	logic        [2:0]     ph_q;
	logic signed [CW-1:0]  ny_q;
	logic        [2:0]     st_q;

	// Arc-start arithmetic.
	logic signed [CW:0]   ncx, ncy;
	logic signed [DW-1:0] ddx, ddy;
	assign ncx = CW'(0) + {cur_x_q[CW-1], cur_x_q} + {off_x[CW-1], off_x};
	assign ncy = {cur_y_q[CW-1], cur_y_q} + {off_y[CW-1], off_y};
	assign ddx = {{2{tgt_x[CW-1]}}, tgt_x} - DW'(ncx);
	assign ddy = {{2{tgt_y[CW-1]}}, tgt_y} - DW'(ncy);

	// Arc end test on current registers.
	logic signed [DW-1:0] px, exd, ry;
	logic                 arc_fin;
	assign px  = DW'(cur_x_q) - DW'(cx_q);
	assign exd = DW'(ex_q) - DW'(cx_q);
	assign ry  = DW'(cur_y_q) - DW'(cy_q);
	assign arc_fin = (cur_y_q == ey_q) && ((px[DW-1] == exd[DW-1]) || px == '0 || exd == '0);

	logic signed [DW-1:0] ldx, ldy;
	assign ldx = DW'(ex_q) - DW'(sx_q);
	assign ldy = DW'(ey_q) - DW'(sy_q);

	logic        [PW-1:0] sub;
	logic                 ge;
	assign sub = rem_q - (sqrt_q ? (acc_q + bit_q) : den_q[PW-1:0]);
	assign ge  = sqrt_q ? (rem_q >= acc_q + bit_q) : ({DW'(0), rem_q} >= den_q);

	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod, prod_y;
	assign prod   = mul_a * mul_b;
	assign prod_y = ddy * ddy;

	logic [STEP_BITS-1:0] steps_n;
	assign steps_n = (steps_q == '1) ? steps_q : steps_q + 1'b1;

	assign stat.busy   = busy_q;
	assign stat.finish = fin_q;
	assign pt_x        = cur_x_q;
	assign pt_y        = cur_y_q;
	assign pt_status   = st_q;

	logic signed [DW-1:0] ydiff;
	assign ydiff = DW'(ny_q) - DW'(cy_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.op == OP_START) begin
			mul_a = ddx; mul_b = ddx;
		end else if (ph_q == 3'd1) begin
			mul_a = DW'(ny_q) - DW'(sy_q);
			mul_b = ldx;
		end else if (ph_q == 3'd4) begin
			mul_a = ydiff; mul_b = ydiff;
		end
	end

	// Status at the end of a step: ST_LIMIT when d is clear and the count has reached the limit, else s.
	function automatic logic [2:0] end_status(input logic d, input logic [2:0] s,
		input logic [STEP_BITS-1:0] n, input logic [STEP_BITS-1:0] m);
		if (!d && n >= m) return ST_LIMIT;
		return s;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0; cur_y_q <= '0; sx_q <= '0; sy_q <= '0;
			ex_q <= '0; ey_q <= '0; cx_q <= '0; cy_q <= '0; r2_q <= '0;
			qm_q <= '0; mode_q <= MODE_IDLE; steps_q <= '0;
			busy_q <= 1'b0; fin_q <= 1'b0; ph_q <= '0; st_q <= ST_IDLE;
			rem_q <= '0; acc_q <= '0; bit_q <= '0; den_q <= '0; cnt_q <= '0;
			neg_q <= 1'b0; sqrt_q <= 1'b0; side_q <= 1'b0; ny_q <= '0;
		end else begin
			fin_q <= 1'b0;
			case (cmd.op)
				OP_START: begin
					sx_q <= cur_x_q; sy_q <= cur_y_q;
					ex_q <= tgt_x; ey_q <= tgt_y;
					steps_q <= '0; qm_q <= '0;
					if (in_cmd == CMD_LINE) begin
						mode_q <= MODE_LINE;
					end else begin
						cx_q <= ncx; cy_q <= ncy;
						r2_q <= PW'(prod) + PW'(prod_y);
						mode_q <= ccw_in ? MODE_ARC_CCW : MODE_ARC_CW;
					end
				end
				OP_QUICK: begin
					cur_x_q <= tgt_x; cur_y_q <= tgt_y; mode_q <= MODE_IDLE;
				end
				OP_STEP: begin
					busy_q <= 1'b1;
					if (mode_q == MODE_IDLE) begin
						st_q <= ST_IDLE; fin_q <= 1'b1; busy_q <= 1'b0;
					end else if (mode_q == MODE_LINE) begin
						if (ldx == '0 || ldy == '0 || cur_y_q == ey_q ||
							cur_y_q + (ldy[DW-1] ? -1 : 1) == ey_q) begin
							cur_x_q <= ex_q; cur_y_q <= ey_q;
							st_q <= ST_DONE; mode_q <= MODE_IDLE;
							steps_q <= steps_n; fin_q <= 1'b1; busy_q <= 1'b0;
						end else begin
							ny_q <= ldy[DW-1] ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
							ph_q <= 3'd1;
						end
					end else if (arc_fin) begin
						st_q <= quad_err(qm_q) ? ST_ARCERR : ST_DONE;
						mode_q <= MODE_IDLE; steps_q <= steps_n;
						fin_q <= 1'b1; busy_q <= 1'b0;
					end else begin
						if (mode_q == MODE_ARC_CCW && (!px[DW-1] && px != '0 ||
							px == '0 && ry[DW-1])) begin
							qm_q[0] <= 1'b1; ny_q <= cur_y_q + 1'b1; side_q <= 1'b1;
							ph_q <= 3'd4;
						end else if (mode_q == MODE_ARC_CCW && (px[DW-1] ||
							px == '0 && ry != '0)) begin
							qm_q[1] <= 1'b1; ny_q <= cur_y_q - 1'b1; side_q <= 1'b0;
							ph_q <= 3'd4;
						end else if (mode_q == MODE_ARC_CW && (!px[DW-1] && px != '0 ||
							px == '0 && !ry[DW-1] && ry != '0)) begin
							qm_q[2] <= 1'b1; ny_q <= cur_y_q - 1'b1; side_q <= 1'b1;
							ph_q <= 3'd4;
						end else if (mode_q == MODE_ARC_CW && (px[DW-1] ||
							px == '0 && ry[DW-1])) begin
							qm_q[3] <= 1'b1; ny_q <= cur_y_q + 1'b1; side_q <= 1'b0;
							ph_q <= 3'd4;
						end else begin
							// Position sits on the centre: no rule applies.
							st_q <= ST_ARCERR; mode_q <= MODE_IDLE; steps_q <= steps_n;
							fin_q <= 1'b1; busy_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase

			case (ph_q)
				3'd1: begin
					// Set up the restoring divider on magnitudes.
					neg_q <= prod[PW-1] ^ ldy[DW-1];
					rem_q <= prod[PW-1] ? PW'(-prod) : PW'(prod);
					den_q <= VW'(ldy[DW-1] ? -ldy : ldy) << (PW - 1);
					acc_q <= '0; sqrt_q <= 1'b0;
					cnt_q <= CNW'(PW); ph_q <= 3'd2;
				end
				3'd2: begin
					if (cnt_q == '0) begin
						ph_q <= 3'd3;
					end else begin
						if (ge) rem_q <= sub;
						acc_q <= {acc_q[PW-2:0], ge};
						den_q <= den_q >> 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				3'd3: begin
					cur_x_q <= CW'(sx_q + (neg_q ? CW'(-acc_q) : CW'(acc_q)));
					cur_y_q <= ny_q;
					st_q <= end_status(1'b0, ST_MOVING, steps_n, max_steps);
					if (steps_n >= max_steps) mode_q <= MODE_IDLE;
					steps_q <= steps_n;
					ph_q <= 3'd0; fin_q <= 1'b1; busy_q <= 1'b0;
				end
				3'd4: begin
					if (PW'(prod) >= r2_q) begin
						rem_q <= '0;
					end else begin
						rem_q <= r2_q - PW'(prod);
					end
					acc_q <= '0; sqrt_q <= 1'b1;
					bit_q <= PW'(1) << (PW - 2);
					cnt_q <= CNW'(RW); ph_q <= 3'd5;
				end
				3'd5: begin
					if (cnt_q == '0) begin
						ph_q <= 3'd7;
						cur_y_q <= ny_q;
						cur_x_q <= side_q ? CW'(cx_q + CW'(acc_q)) : CW'(cx_q - CW'(acc_q));
					end else begin
						if (ge) begin
							rem_q <= sub;
							acc_q <= (acc_q >> 1) + bit_q;
						end else begin
							acc_q <= acc_q >> 1;
						end
						bit_q <= bit_q >> 2;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				3'd7: begin
					if (arc_fin) begin
						st_q <= quad_err(qm_q) ? ST_ARCERR : ST_DONE;
						mode_q <= MODE_IDLE;
					end else begin
						st_q <= end_status(1'b0, ST_MOVING, steps_n, max_steps);
						if (steps_n >= max_steps) mode_q <= MODE_IDLE;
					end
					steps_q <= steps_n;
					ph_q <= 3'd0; fin_q <= 1'b1; busy_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTH
	a_fin_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> !fin_q) else $error("finish held");
	a_idle_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> !busy_q) else $error("busy at finish");
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q && (st_q == ST_DONE || st_q == ST_LIMIT || st_q == ST_ARCERR)
		|-> mode_q == MODE_IDLE) else $error("move not ended");
`endif

endmodule
